/* design/gbts_pkg.sv */
`default_nettype none

package gbts_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = 8;
  localparam int POS_W    = 9;

  localparam logic [2:0] FN_INSERT     = 3'd0;
  localparam logic [2:0] FN_DEL_BEFORE = 3'd1;
  localparam logic [2:0] FN_DEL_AFTER  = 3'd2;
  localparam logic [2:0] FN_MOVE       = 3'd3;
  localparam logic [2:0] FN_READ       = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MV_CHK,
    S_MV_RD,
    S_MV_WR,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mv_rd;
    logic mv_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_move;
    logic move_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/gap_buffer_text_store_core.sv */
// Gap buffer text store: a 256-byte text held in one RAM with a movable gap.
// Input channel (in_valid/in_ready) carries one operation word: func selects
// insert, delete before the gap, delete after the gap, move gap, or read;
// char_in is the byte to insert and position the text position for move/read.
// Output channel (out_valid/out_ready) returns one result word per operation:
// char_out, text_length, gap_position (the cursor) and status.
// Insert, delete, read and unused codes pass through the execute and finish
// states before the result is loaded. A move adds a compare step, then for
// each byte carried across the gap one RAM read, one RAM write and a compare
// step.
// One operation is in flight at a time; in_ready is high only while the
// controller is idle, so a new word is taken only once the previous one has
// finished, even if the previous result is unclaimed.
// When the receiver stalls, a finished result waits in the output register
// and the following operation holds before its own result is written.
// Reset (rst, synchronous) empties the text: gap at 0, gap end at 256.
// RAM contents are not cleared; only bytes written by insert or by a move are ever read.

`default_nettype none

module gap_buffer_text_store_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 func,
  input  wire logic [7:0]                 char_in,
  input  wire logic [gbts_pkg::POS_W-1:0] position,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      char_out,
  output logic [gbts_pkg::POS_W-1:0]      text_length,
  output logic [gbts_pkg::POS_W-1:0]      gap_position,
  output logic [1:0]                      status
);
  import gbts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbts_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .char_in      (char_in),
    .position     (position),
    .char_out     (char_out),
    .text_length  (text_length),
    .gap_position (gap_position),
    .status       (status)
  );

endmodule

`default_nettype wire

/* design/gbts_ctrl.sv */
`default_nettype none

module gbts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire gbts_pkg::dp_stat_t stat,
  output gbts_pkg::dp_cmd_t      cmd
);
  import gbts_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_move ? S_MV_CHK : S_FIN;
      end
      S_MV_CHK: begin
        state_next = stat.move_busy ? S_MV_RD : S_FIN;
      end
      S_MV_RD: begin
        cmd.mv_rd  = 1'b1;
        state_next = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.mv_wr  = 1'b1;
        state_next = S_MV_CHK;
      end
      S_FIN: begin
        // The result register may still hold an unclaimed word.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_EXEC)
    else $error("accepted word did not start execution");
  assert property (@(posedge clk) disable iff (rst) cmd.mv_rd |=> cmd.mv_wr)
    else $error("move read not followed by its write");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

`default_nettype wire

/* design/gbts_datapath.sv */
`default_nettype none

module gbts_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gbts_pkg::dp_cmd_t           cmd,
  output gbts_pkg::dp_stat_t               stat,
  input  wire logic [2:0]                  func,
  input  wire logic [7:0]                  char_in,
  input  wire logic [gbts_pkg::POS_W-1:0]  position,
  output logic [7:0]                       char_out,
  output logic [gbts_pkg::POS_W-1:0]       text_length,
  output logic [gbts_pkg::POS_W-1:0]       gap_position,
  output logic [1:0]                       status
);
  import gbts_pkg::*;

  logic [7:0]        mem [CAPACITY];
  logic [7:0]        rdata;

  logic [2:0]        op_func;
  logic [7:0]        op_char;
  logic [POS_W-1:0]  op_pos;

  logic [POS_W-1:0]  gap_low, gap_low_next;
  logic [POS_W-1:0]  gap_high, gap_high_next;
  logic [POS_W-1:0]  target, target_next;
  logic [1:0]        status_r, status_r_next;
  logic              rd_hit, rd_hit_next;

  logic [POS_W:0]    len_wide;
  logic [POS_W-1:0]  len;
  logic [POS_W-1:0]  phys;
  logic              move_right;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign len_wide   = {1'b0, gap_low} + (POS_W+1)'(CAPACITY) - {1'b0, gap_high};
  assign len        = len_wide[POS_W-1:0];
  assign phys       = (op_pos < gap_low) ? op_pos : op_pos + (gap_high - gap_low);
  assign move_right = target > gap_low;

  assign stat.is_move   = (op_func == FN_MOVE);
  assign stat.move_busy = (gap_low != target);

  always_comb begin
    gap_low_next  = gap_low;
    gap_high_next = gap_high;
    target_next   = target;
    status_r_next = status_r;
    rd_hit_next   = rd_hit;
    wr_en         = 1'b0;
    wr_addr       = gap_low[ADDR_W-1:0];
    wr_data       = op_char;
    rd_en         = 1'b0;
    rd_addr       = phys[ADDR_W-1:0];

    if (cmd.load) begin
      status_r_next = ST_DONE;
      rd_hit_next   = 1'b0;
      target_next   = gap_low;
    end

    if (cmd.exec) begin
      case (op_func)
        FN_INSERT: begin
          if (gap_low >= gap_high) begin
            status_r_next = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            gap_low_next = gap_low + 1'b1;
          end
        end
        FN_DEL_BEFORE: begin
          if (gap_low == '0) begin
            status_r_next = ST_EMPTY;
          end else begin
            gap_low_next = gap_low - 1'b1;
          end
        end
        FN_DEL_AFTER: begin
          if (gap_high >= POS_W'(CAPACITY)) begin
            status_r_next = ST_EMPTY;
          end else begin
            gap_high_next = gap_high + 1'b1;
          end
        end
        FN_MOVE: begin
          if (op_pos > len) begin
            target_next   = len;
            status_r_next = ST_RANGE;
          end else begin
            target_next = op_pos;
          end
        end
        FN_READ: begin
          if (op_pos >= len) begin
            status_r_next = ST_RANGE;
          end else begin
            rd_en       = 1'b1;
            rd_hit_next = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // One byte crosses the gap per read/write pair.
    if (cmd.mv_rd) begin
      rd_en   = 1'b1;
      rd_addr = move_right ? gap_high[ADDR_W-1:0] : ADDR_W'(gap_low - 1'b1);
    end

    if (cmd.mv_wr) begin
      wr_en   = 1'b1;
      wr_data = rdata;
      if (move_right) begin
        wr_addr       = gap_low[ADDR_W-1:0];
        gap_low_next  = gap_low + 1'b1;
        gap_high_next = gap_high + 1'b1;
      end else begin
        wr_addr       = ADDR_W'(gap_high - 1'b1);
        gap_low_next  = gap_low - 1'b1;
        gap_high_next = gap_high - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_low  <= '0;
      gap_high <= POS_W'(CAPACITY);
      target   <= '0;
      status_r <= ST_DONE;
      rd_hit   <= 1'b0;
    end else begin
      gap_low  <= gap_low_next;
      gap_high <= gap_high_next;
      target   <= target_next;
      status_r <= status_r_next;
      rd_hit   <= rd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_char <= char_in;
      op_pos  <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      char_out     <= rd_hit ? rdata : 8'd0;
      text_length  <= len;
      gap_position <= gap_low;
      status       <= status_r;
    end
  end

  assert property (@(posedge clk) disable iff (rst) gap_low <= gap_high)
    else $error("gap start passed gap end");
  assert property (@(posedge clk) disable iff (rst)
                   cmd.mv_wr |=> (gap_high - gap_low) == $past(gap_high - gap_low))
    else $error("gap width changed during a move");
  assert property (@(posedge clk) disable iff (rst)
                   cmd.mv_wr |=> target == $past(target))
    else $error("move target changed during a move");

endmodule

`default_nettype wire
